// File: rtl/lmsfw_pkg.sv
// Shared types, constants and the microcode table of the LED matrix serial frame writer.
package lmsfw_pkg;

  // Field widths
  localparam int ModeW  = 3;
  localparam int ValueW = 8;
  localparam int UpcW   = 3;
  localparam int CntW   = 4;
  localparam int ShiftW = 9;

  // Operation codes on the mode field
  localparam logic [ModeW-1:0] ModeStart  = 3'd0;
  localparam logic [ModeW-1:0] ModeCmd    = 3'd1;
  localparam logic [ModeW-1:0] ModeAddr   = 3'd2;
  localparam logic [ModeW-1:0] ModeData   = 3'd3;
  localparam logic [ModeW-1:0] ModeDesel  = 3'd4;

  // Microprogram entry points
  localparam logic [UpcW-1:0] UpcIdle    = 3'd0;
  localparam logic [UpcW-1:0] UpcStart   = 3'd1;
  localparam logic [UpcW-1:0] UpcSelect  = 3'd2;
  localparam logic [UpcW-1:0] UpcBitLow  = 3'd3;
  localparam logic [UpcW-1:0] UpcBitHigh = 3'd4;
  localparam logic [UpcW-1:0] UpcDesel   = 3'd5;

  // Largest bit loop count (command: eight bits plus the trailing zero, counted after the first bit)
  localparam logic [CntW-1:0] CntMax = 4'd8;

  typedef enum logic [1:0] {
    SEL_KEEP = 2'd0,
    SEL_SET  = 2'd1,
    SEL_CLR  = 2'd2
  } sel_op_e;

  typedef enum logic [1:0] {
    SEQ_WAIT = 2'd0,
    SEQ_NEXT = 2'd1,
    SEQ_LOOP = 2'd2,
    SEQ_DONE = 2'd3
  } seq_e;

  // One control word of the microprogram
  typedef struct packed {
    logic            emit;
    logic            clk;
    logic            from_shift;
    logic            shift;
    sel_op_e         sel_op;
    seq_e            seq;
    logic [UpcW-1:0] target;
  } uc_word_t;

  // Per-cycle controls from the sequencer to the datapath
  typedef struct packed {
    logic    load;
    logic    fire;
    logic    clk;
    logic    from_shift;
    logic    shift;
    sel_op_e sel_op;
    logic    last;
  } uc_ctrl_t;

  // Microcode table
  function automatic uc_word_t uc_rom(input logic [UpcW-1:0] addr);
    uc_word_t w;
    w = '{emit: 1'b0, clk: 1'b1, from_shift: 1'b0, shift: 1'b0,
          sel_op: SEL_KEEP, seq: SEQ_WAIT, target: UpcIdle};
    case (addr)
      UpcStart: begin
        w.emit = 1'b1; w.sel_op = SEL_SET; w.seq = SEQ_NEXT;
      end
      UpcSelect: begin
        w.emit = 1'b1; w.sel_op = SEL_CLR; w.seq = SEQ_NEXT;
      end
      UpcBitLow: begin
        w.emit = 1'b1; w.clk = 1'b0; w.from_shift = 1'b1; w.seq = SEQ_NEXT;
      end
      UpcBitHigh: begin
        w.emit = 1'b1; w.shift = 1'b1; w.seq = SEQ_LOOP; w.target = UpcBitLow;
      end
      UpcDesel: begin
        w.emit = 1'b1; w.sel_op = SEL_SET; w.seq = SEQ_DONE;
      end
      default: begin
        w.seq = SEQ_WAIT;
      end
    endcase
    return w;
  endfunction

  // Microprogram entry for an operation
  function automatic logic [UpcW-1:0] mode_entry(input logic [ModeW-1:0] mode);
    logic [UpcW-1:0] e;
    case (mode)
      ModeStart: e = UpcStart;
      ModeCmd:   e = UpcBitLow;
      ModeAddr:  e = UpcBitLow;
      ModeData:  e = UpcBitLow;
      ModeDesel: e = UpcDesel;
      default:   e = UpcIdle;
    endcase
    return e;
  endfunction

  // Bits still to send after the first one
  function automatic logic [CntW-1:0] mode_count(input logic [ModeW-1:0] mode);
    logic [CntW-1:0] c;
    case (mode)
      ModeStart: c = 4'd2;
      ModeCmd:   c = CntMax;
      ModeAddr:  c = 4'd6;
      ModeData:  c = 4'd3;
      default:   c = 4'd0;
    endcase
    return c;
  endfunction

  // Serial bits aligned so the first bit sits at the top of the shifter
  function automatic logic [ShiftW-1:0] mode_bits(input logic [ModeW-1:0] mode,
                                                  input logic [ValueW-1:0] value);
    logic [ShiftW-1:0] b;
    case (mode)
      ModeStart: b = {value[2:0], 6'd0};
      ModeCmd:   b = {value, 1'b0};
      ModeAddr:  b = {value[6:0], 2'd0};
      ModeData:  b = {value[0], value[1], value[2], value[3], 5'd0};
      default:   b = '0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/lmsfw_if.sv
// Valid/ready channel interfaces for operations in and pin snapshots out.
interface lmsfw_in_if;
  import lmsfw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface lmsfw_out_if;
  logic valid;
  logic ready;
  logic chip_select_n;
  logic write_clock;
  logic data_line;
  logic last;

  modport source (output valid, output chip_select_n, output write_clock,
                  output data_line, output last, input ready);
  modport sink   (input valid, input chip_select_n, input write_clock,
                  input data_line, input last, output ready);
endinterface

// File: rtl/led_matrix_serial_frame_writer.sv
// Top level of the LED matrix three-wire serial frame writer.
// After an operation is accepted the sequencer moves to its entry step, which registers the
// first pin snapshot when the output slot is free. Throughput: one snapshot per cycle while
// the output is ready (start 8 snapshots, command 18, address 14, data 8, deselect 1).
// The rate is set by the microprogram, which emits one snapshot per step but for its idle step.
// Reset leaves chip select high, data level low and the sequencer idle, ready for input.
module led_matrix_serial_frame_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmsfw_in_if.sink    in_i,
  lmsfw_out_if.source out_o
);
  import lmsfw_pkg::*;

  uc_ctrl_t ctrl;
  logic     out_free;

  lmsfw_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .mode_i     (in_i.mode),
    .out_free_i (out_free),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  lmsfw_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .mode_i          (in_i.mode),
    .value_i         (in_i.value),
    .out_ready_i     (out_o.ready),
    .out_free_o      (out_free),
    .out_valid_o     (out_o.valid),
    .chip_select_n_o (out_o.chip_select_n),
    .write_clock_o   (out_o.write_clock),
    .data_line_o     (out_o.data_line),
    .last_o          (out_o.last)
  );

endmodule

// File: rtl/lmsfw_sequencer.sv
// Microprogram counter, bit loop counter and control word decode.
module lmsfw_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [lmsfw_pkg::ModeW-1:0] mode_i,
  input  logic                      out_free_i,
  output logic                      in_ready_o,
  output lmsfw_pkg::uc_ctrl_t       ctrl_o
);
  import lmsfw_pkg::*;

  logic [UpcW-1:0] upc_q, upc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  uc_word_t        word;
  logic            adv;
  logic            accept;
  logic            cnt_zero;

  // Control word fetch
  assign word     = uc_rom(upc_q);
  assign adv      = !word.emit || out_free_i;
  assign cnt_zero = (cnt_q == '0);
  assign accept   = in_valid_i && (word.seq == SEQ_WAIT);

  assign in_ready_o = (word.seq == SEQ_WAIT);

  // Next step
  always_comb begin
    upc_d = upc_q;
    cnt_d = cnt_q;
    case (word.seq)
      SEQ_WAIT: begin
        if (in_valid_i) begin
          upc_d = mode_entry(mode_i);
          cnt_d = mode_count(mode_i);
        end
      end
      SEQ_NEXT: begin
        if (adv) upc_d = upc_q + 1'b1;
      end
      SEQ_LOOP: begin
        if (adv) begin
          if (cnt_zero) begin
            upc_d = UpcIdle;
          end else begin
            upc_d = word.target;
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      SEQ_DONE: begin
        if (adv) upc_d = UpcIdle;
      end
      default: begin
        upc_d = UpcIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcIdle;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  // Controls to the datapath
  always_comb begin
    ctrl_o.load       = accept;
    ctrl_o.fire       = word.emit && adv;
    ctrl_o.clk        = word.clk;
    ctrl_o.from_shift = word.from_shift;
    ctrl_o.shift      = word.shift;
    ctrl_o.sel_op     = word.sel_op;
    ctrl_o.last       = (word.seq == SEQ_DONE) || ((word.seq == SEQ_LOOP) && cnt_zero);
  end

  // Loop count never exceeds the longest frame
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("bit loop counter out of range");

  // Step counter stays within the program
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= UpcDesel)
    else $error("step counter outside the microprogram");

  // A known operation always starts the program
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i <= ModeDesel)) |=> (upc_q != UpcIdle))
    else $error("accepted operation did not start");

  // A held snapshot freezes the program
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word.emit && !out_free_i) |=> $stable(upc_q) && $stable(cnt_q))
    else $error("sequencer advanced while output stalled");

endmodule

// File: rtl/lmsfw_datapath.sv
// Shifter, line level state and the snapshot output register.
module lmsfw_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lmsfw_pkg::uc_ctrl_t          ctrl_i,
  input  logic [lmsfw_pkg::ModeW-1:0]  mode_i,
  input  logic [lmsfw_pkg::ValueW-1:0] value_i,
  input  logic                         out_ready_i,
  output logic                         out_free_o,
  output logic                         out_valid_o,
  output logic                         chip_select_n_o,
  output logic                         write_clock_o,
  output logic                         data_line_o,
  output logic                         last_o
);
  import lmsfw_pkg::*;

  logic [ShiftW-1:0] shift_q;
  logic              select_q, select_d;
  logic              data_level_q, data_level_d;
  logic              valid_q;
  logic              cs_q, clk_q, data_q, last_q;

  // Line levels for the snapshot of this step
  always_comb begin
    case (ctrl_i.sel_op)
      SEL_SET: select_d = 1'b1;
      SEL_CLR: select_d = 1'b0;
      default: select_d = select_q;
    endcase
    data_level_d = ctrl_i.from_shift ? shift_q[ShiftW-1] : data_level_q;
  end

  // Line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_q     <= 1'b1;
      data_level_q <= 1'b0;
    end else if (ctrl_i.fire) begin
      select_q     <= select_d;
      data_level_q <= data_level_d;
    end
  end

  // Serial bit shifter
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      shift_q <= mode_bits(mode_i, value_i);
    end else if (ctrl_i.fire && ctrl_i.shift) begin
      shift_q <= {shift_q[ShiftW-2:0], 1'b0};
    end
  end

  // Output register
  assign out_free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.fire) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      cs_q   <= select_d;
      clk_q  <= ctrl_i.clk;
      data_q <= data_level_d;
      last_q <= ctrl_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign chip_select_n_o = cs_q;
  assign write_clock_o   = clk_q;
  assign data_line_o     = data_q;
  assign last_o          = last_q;

  // A snapshot is only loaded into a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fire |-> out_free_o)
    else $error("snapshot overwrote a pending transaction");

  // The low clock phase always comes with a data update from the shifter
  a_low_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fire && !ctrl_i.clk) |-> ctrl_i.from_shift)
    else $error("clock low snapshot without a new data bit");

  // Data line only changes on a clock low snapshot
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fire && ctrl_i.clk) |=> $stable(data_level_q))
    else $error("data level changed with clock high");

endmodule

// File: verif/led_matrix_serial_frame_writer_tb.sv
// Self-checking testbench for the LED matrix three-wire serial frame writer.
module led_matrix_serial_frame_writer_tb;
  import lmsfw_pkg::*;

  // One operation for the input channel
  typedef struct {
    logic [ModeW-1:0]  mode;
    logic [ValueW-1:0] value;
  } op_item_t;

  // One pin snapshot on the output channel
  typedef struct packed {
    logic cs_n;
    logic wclk;
    logic dat;
    logic last;
  } pin_snap_t;

  localparam int RandomOps  = 280;
  localparam int MaxGap     = 16;
  localparam int HoldCycles = 300;
  localparam int HoldAfter  = 60;
  localparam int DrainWait  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  lmsfw_in_if  op_if ();
  lmsfw_out_if pin_if ();

  led_matrix_serial_frame_writer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (pin_if)
  );

  // Clock: period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  op_item_t  op_queue[$];
  pin_snap_t snap_due_q[$];

  int err_cnt   = 0;
  int total_ops = 0;
  int live_ops  = 0;
  int shown_cnt = 0;
  int taken_cnt = 0;
  int rx_seen   = 0;
  int rx_ack    = 0;
  int send_gap  = 0;
  int rx_stall  = 0;
  int hold_cnt  = 0;
  bit hold_done = 1'b0;

  // Predictor state
  logic             cs_lvl;
  logic [ModeW-1:0] mode_id_lvl;
  logic             dat_lvl;

  // Idle count per transaction, mostly zero so that bursts occur
  function automatic int draw_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  task automatic put_snap(input logic wclk, input logic dat);
    pin_snap_t s;
    s = '{cs_n: cs_lvl, wclk: wclk, dat: dat, last: 1'b0};
    snap_due_q.push_back(s);
  endtask

  // A serial bit: clock low then clock high, data held
  task automatic put_bit(input logic b);
    dat_lvl = b;
    put_snap(1'b0, dat_lvl);
    put_snap(1'b1, dat_lvl);
  endtask

  task automatic put_msb(input logic [ValueW-1:0] v, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) put_bit(v[i]);
  endtask

  // Expected snapshots for one accepted operation
  task automatic predict_pins(input logic [ModeW-1:0] mode, input logic [ValueW-1:0] value);
    int first;
    first = snap_due_q.size();
    case (mode)
      ModeStart: begin
        cs_lvl = 1'b1;
        put_snap(1'b1, dat_lvl);
        cs_lvl = 1'b0;
        put_snap(1'b1, dat_lvl);
        put_msb(value, 3);
        mode_id_lvl = value[2:0];
      end
      ModeCmd: begin
        put_msb(value, 8);
        put_bit(1'b0);
      end
      ModeAddr: begin
        put_msb(value, 7);
      end
      ModeData: begin
        for (int i = 0; i < 4; i++) put_bit(value[i]);
      end
      ModeDesel: begin
        cs_lvl = 1'b1;
        put_snap(1'b1, dat_lvl);
      end
      default: begin
        // unknown operation: no snapshots, state kept
      end
    endcase
    if (snap_due_q.size() > first) snap_due_q[$].last = 1'b1;
  endtask

  task automatic check_bit(input string field, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %b actual %b", $time, field, want, got);
      err_cnt++;
    end
  endtask

  task automatic add_op(input logic [ModeW-1:0] mode, input logic [ValueW-1:0] value);
    op_item_t it;
    it.mode  = mode;
    it.value = value;
    op_queue.push_back(it);
    if (mode <= ModeDesel) live_ops++;
  endtask

  // Monitor and predictor: sample both channels at the rising edge
  always @(posedge clk_i) begin
    pin_snap_t want;
    if (rst_ni) begin
      if (pin_if.valid && pin_if.ready) begin
        if (snap_due_q.size() == 0) begin
          $display("%0t: unexpected snapshot, expected none actual cs_n=%b wclk=%b dat=%b last=%b",
                   $time, pin_if.chip_select_n, pin_if.write_clock, pin_if.data_line,
                   pin_if.last);
          err_cnt++;
        end else begin
          want = snap_due_q.pop_front();
          check_bit("chip_select_n", want.cs_n, pin_if.chip_select_n);
          check_bit("write_clock", want.wclk, pin_if.write_clock);
          check_bit("data_line", want.dat, pin_if.data_line);
          check_bit("last", want.last, pin_if.last);
        end
        rx_seen++;
      end
      if (op_if.valid && op_if.ready) begin
        predict_pins(op_if.mode, op_if.value);
        taken_cnt++;
      end
    end
  end

  // Driver: present queued operations at the falling edge
  always @(negedge clk_i) begin
    op_item_t cur;
    if (rst_ni) begin
      if (!(op_if.valid && taken_cnt != shown_cnt)) begin
        if (send_gap != 0) begin
          send_gap--;
          op_if.valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          cur = op_queue.pop_front();
          op_if.mode  <= cur.mode;
          op_if.value <= cur.value;
          op_if.valid <= 1'b1;
          shown_cnt++;
          send_gap = draw_gap();
        end else begin
          op_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && taken_cnt >= HoldAfter) begin
        hold_cnt  <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // Receiver: random stall after each accepted snapshot
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_seen != rx_ack) begin
        rx_ack   = rx_seen;
        rx_stall = draw_gap();
      end
      if (rx_stall != 0) begin
        rx_stall--;
        pin_if.ready <= 1'b0;
      end else begin
        pin_if.ready <= (hold_cnt == 0);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    rst_ni       = 1'b0;
    op_if.valid  = 1'b0;
    op_if.mode   = ModeStart;
    op_if.value  = '0;
    pin_if.ready = 1'b0;
    cs_lvl       = 1'b1;
    mode_id_lvl  = '0;
    dat_lvl      = 1'b0;

    // Directed: field extremes, every operation, corner cases
    add_op(ModeCmd, 8'hFF);            // bits clocked while still deselected
    add_op(ModeStart, 8'hFF);          // unused value bits set
    add_op(ModeCmd, 8'h00);
    add_op(ModeCmd, 8'hFF);
    add_op(ModeCmd, 8'hA5);
    add_op(ModeAddr, 8'h7F);
    add_op(ModeAddr, 8'h80);           // only the ignored top bit set
    add_op(ModeData, 8'h0F);
    add_op(ModeData, 8'hF0);           // only ignored bits set
    add_op(ModeData, 8'h01);
    add_op(ModeDesel, 8'hFF);
    add_op(ModeAddr, 8'h55);           // deselected again
    add_op(ModeData, 8'h0A);
    add_op(ModeDesel, 8'h00);
    add_op(ModeStart, 8'h00);
    add_op(ModeStart, 8'h05);          // start while already selected
    add_op(ModeDesel + 3'd1, 8'hFF);   // unknown operations
    add_op(ModeDesel + 3'd2, 8'h00);
    add_op(ModeDesel + 3'd3, 8'h5A);
    add_op(ModeData, 8'h08);
    add_op(ModeDesel, 8'h00);
    add_op(ModeDesel, 8'hFF);          // repeated deselect

    // Random: mostly well-formed frames, some noise
    live_ops = 0;
    while (live_ops < RandomOps) begin
      if ($urandom_range(0, 9) == 0) begin
        add_op(ModeW'($urandom_range(0, (1 << ModeW) - 1)), ValueW'($urandom_range(0, 255)));
      end else begin
        add_op(ModeStart, ValueW'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 2))
            0: add_op(ModeCmd, ValueW'($urandom_range(0, 255)));
            1: add_op(ModeAddr, ValueW'($urandom_range(0, 255)));
            default: add_op(ModeData, ValueW'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 4) != 0) add_op(ModeDesel, ValueW'($urandom_range(0, 255)));
      end
    end
    total_ops = op_queue.size();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every operation to be taken and every snapshot to arrive
    do @(negedge clk_i); while (taken_cnt != total_ops || snap_due_q.size() != 0);
    repeat (DrainWait) @(negedge clk_i);

    if (snap_due_q.size() != 0) begin
      $display("%0t: %0d snapshots never arrived, expected 0 pending actual %0d",
               $time, snap_due_q.size(), snap_due_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("led_matrix_serial_frame_writer_tb: done, clean");
    end else begin
      $display("led_matrix_serial_frame_writer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("led_matrix_serial_frame_writer_tb: done, errors");
    $finish;
  end

endmodule
